// File: hw/rtl/srat_pkg.sv
package srat_pkg;

    localparam int SRAT_REGIONS = 16;
    localparam int COUNT_W      = 5;
    localparam int INDEX_W      = 4;
    localparam int ADDR_W       = 64;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_FORWARD = 2'd1,
        KIND_REVERSE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOREGION = 3'd1,
        ST_OFFSET   = 3'd2,
        ST_EXTENT   = 3'd3,
        ST_WANTED   = 3'd4
    } status_t;

    typedef struct packed {
        kind_t               kind;
        logic [INDEX_W-1:0]  region_index;
        logic [ADDR_W-1:0]   address;
        logic [ADDR_W-1:0]   region_size;
        logic [ADDR_W-1:0]   ref_offset;
        logic [ADDR_W-1:0]   ref_length;
        logic [ADDR_W-1:0]   length;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  found_index;
        logic [ADDR_W-1:0]   found_offset;
        logic [ADDR_W-1:0]   found_length;
        logic [ADDR_W-1:0]   resolved_address;
    } rsp_t;

    // what travels from one cell to the next
    typedef struct packed {
        logic                valid;
        req_t                req;
        logic                found;
        logic [INDEX_W-1:0]  hit;
        logic [ADDR_W-1:0]   off;
        logic [ADDR_W-1:0]   sel_base;
        logic [ADDR_W-1:0]   sel_size;
    } link_t;

endpackage

// File: hw/rtl/srat_cell.sv
module srat_cell import srat_pkg::*; #(
    parameter int CELL_ID = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [COUNT_W-1:0] region_count,
    input  link_t              link_in,
    output link_t              link_out
);

    logic [ADDR_W-1:0] base_reg;
    logic [ADDR_W-1:0] size_reg;
    link_t             link_reg;
    link_t             link_next;

    logic              idx_match;
    logic              in_use;
    logic [ADDR_W-1:0] diff;
    logic              hit_here;

    assign idx_match = (32'(link_in.req.region_index) == CELL_ID);
    assign in_use    = (32'(region_count) > CELL_ID);
    assign diff      = link_in.req.address - base_reg;
    // a zero-size region never matches since diff < 0 is impossible
    assign hit_here  = in_use && (link_in.req.address >= base_reg) && (diff < size_reg);

    always_comb begin
        link_next = link_in;
        case (link_in.req.kind)
            KIND_FORWARD: begin
                if (!link_in.found && hit_here) begin
                    link_next.found    = 1'b1;
                    link_next.hit      = INDEX_W'(CELL_ID);
                    link_next.off      = diff;
                    link_next.sel_size = size_reg;
                end
            end
            KIND_REVERSE: begin
                if (idx_match) begin
                    link_next.sel_base = base_reg;
                    link_next.sel_size = size_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg       <= '0;
            size_reg       <= '0;
            link_reg.valid <= 1'b0;
        end else if (adv) begin
            link_reg <= link_next;
            if (link_in.valid && link_in.req.kind == KIND_WRITE && idx_match) begin
                base_reg <= link_in.req.address;
                size_reg <= link_in.req.region_size;
            end
        end
    end

    assign link_out = link_reg;

endmodule

// File: hw/rtl/srat_resolve.sv
module srat_resolve import srat_pkg::*; #(
    parameter int REGIONS = SRAT_REGIONS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic [COUNT_W-1:0] region_count,
    input  link_t              link_in,
    output logic               out_valid,
    output rsp_t               out_data
);

    logic  valid_reg;
    rsp_t  data_reg;
    rsp_t  data_next;
    logic  id_ok;

    assign id_ok = (COUNT_W'(link_in.req.region_index) < region_count)
                && (32'(link_in.req.region_index) < REGIONS);

    always_comb begin
        data_next        = '0;
        data_next.status = ST_OK;
        case (link_in.req.kind)
            KIND_FORWARD: begin
                if (!link_in.found) begin
                    data_next.status = ST_NOREGION;
                end else if (link_in.req.length > link_in.sel_size - link_in.off) begin
                    data_next.status = ST_EXTENT;
                end else begin
                    data_next.found_index  = link_in.hit;
                    data_next.found_offset = link_in.off;
                    data_next.found_length = link_in.req.length;
                end
            end
            KIND_REVERSE: begin
                if (!id_ok) begin
                    data_next.status = ST_NOREGION;
                end else if (link_in.req.ref_offset >= link_in.sel_size) begin
                    data_next.status = ST_OFFSET;
                end else if (link_in.req.ref_length >
                             link_in.sel_size - link_in.req.ref_offset) begin
                    data_next.status = ST_EXTENT;
                end else if (link_in.req.length != '0 &&
                             link_in.req.length > link_in.req.ref_length) begin
                    data_next.status = ST_WANTED;
                end else begin
                    data_next.resolved_address = link_in.sel_base + link_in.req.ref_offset;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= link_in.valid;
            data_reg  <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hw/rtl/shared_region_address_translator_unit.sv
// Region translator built as a chain of REGIONS cells, each cell owning one
// table entry (base and size). Every transaction enters cell 0 and moves one
// cell per cycle; writes land in their cell on the way, forward lookups pick
// up the first in-use region that contains the address, reverse lookups pick
// up the addressed entry. A final registered stage forms the status and
// result, and one transaction is taken per cycle whenever the result side
// keeps up; the whole chain stalls together while a result is waiting with
// m_ready low. The table clears at reset.
// region_count should only be written while no transaction is in flight.
module shared_region_address_translator_unit import srat_pkg::*; #(
    parameter int REGIONS = SRAT_REGIONS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  req_t               s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rsp_t               m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    logic [COUNT_W-1:0] region_count_reg;
    logic               adv;
    link_t              links [REGIONS+1];

    assign adv       = !m_valid || m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_count_reg <= '0;
        end else if (cfg_valid) begin
            region_count_reg <= cfg_data;
        end
    end

    always_comb begin
        links[0]       = '0;
        links[0].valid = s_valid;
        links[0].req   = s_data;
    end

    for (genvar i = 0; i < REGIONS; i++) begin : g_cell
        srat_cell #(.CELL_ID(i)) u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .adv          (adv),
            .region_count (region_count_reg),
            .link_in      (links[i]),
            .link_out     (links[i+1])
        );
    end

    srat_resolve #(.REGIONS(REGIONS)) u_resolve (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .region_count (region_count_reg),
        .link_in      (links[REGIONS]),
        .out_valid    (m_valid),
        .out_data     (m_data)
    );

endmodule

// File: hw/rtl/srat_checker.sv
module srat_checker import srat_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input rsp_t m_data
);

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // failures carry nothing but the status
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |->
            m_data.found_index == '0 && m_data.found_offset == '0 &&
            m_data.found_length == '0 && m_data.resolved_address == '0)
        else $error("failure transaction with nonzero fields");

    // forward and reverse results never mix
    a_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.resolved_address == '0 ||
            (m_data.found_index == '0 && m_data.found_offset == '0 &&
             m_data.found_length == '0))
        else $error("forward and reverse fields both set");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // an empty output stage never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind shared_region_address_translator_unit srat_checker u_srat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
